// File: rtl/spring_jacobian_contribution_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef SPRING_JACOBIAN_CONTRIBUTION_CORE_MACROS_SVH
`define SPRING_JACOBIAN_CONTRIBUTION_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SJC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SJC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed");

`endif

// File: rtl/sjc_pkg.sv
package sjc_pkg;

   localparam int MAX_MASSES = 64;
   localparam int IDX_W      = 6;
   localparam int ROW_W      = IDX_W + 1;
   localparam int POS_W      = 32;
   localparam int MAG_W      = 32;
   localparam int SQ_W       = 2 * MAG_W + 1;
   localparam int ROOT_W     = MAG_W + 1;
   localparam int LEN_W      = 16;
   localparam int FRAC_W     = 16;
   localparam int Q_W        = 32;
   localparam int DIV_W      = Q_W + FRAC_W;
   localparam int U_W        = FRAC_W + 1;
   localparam int VAL_W      = 48;
   localparam int KMAG_W     = 63;
   localparam int ENT_N      = 4;
   localparam int LANE_N     = 3;

   localparam logic [LEN_W-1:0]  MIN_LEN_RST = 16'd1;
   localparam logic [KMAG_W-1:0] SAT_LIM     = 63'h4000_0000_0000_0000;
   localparam logic [VAL_W-1:0]  OUT_MAG_MAX = 48'h8000_0000_0000;
   localparam logic [VAL_W-1:0]  OUT_POS_MAX = 48'h7FFF_FFFF_FFFF;

   // Lanes of the divider.
   localparam int LANE_UX = 0;
   localparam int LANE_UY = 1;
   localparam int LANE_Q  = 2;

   typedef struct packed {
      logic             valid;
      logic             skip;
      logic             mass_a;
      logic             mass_b;
      logic [IDX_W-1:0] idx_a;
      logic [IDX_W-1:0] idx_b;
      logic             neg_x;
      logic             neg_y;
      logic [MAG_W-1:0] mag_x;
      logic [MAG_W-1:0] mag_y;
      logic [Q_W-1:0]   stiff;
      logic [Q_W-1:0]   rest;
      logic [Q_W-1:0]   inv_a;
      logic [Q_W-1:0]   inv_b;
   } side_type;

   typedef struct packed {
      logic                               valid;
      logic                               skip;
      logic                               mass_a;
      logic                               mass_b;
      logic [IDX_W-1:0]                   idx_a;
      logic [IDX_W-1:0]                   idx_b;
      logic [ENT_N-1:0]                   kneg;
      logic [1:0][ENT_N-1:0][VAL_W-1:0]   vsat;
   } emit_type;

endpackage

// File: rtl/sjc_sqrt_pipe.sv
module sjc_sqrt_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  sjc_pkg::side_type             side_in,
   input  logic [sjc_pkg::SQ_W-1:0]      sq_in,
   output sjc_pkg::side_type             side_out,
   output logic [sjc_pkg::ROOT_W-1:0]    root_out
);

   localparam int N  = sjc_pkg::ROOT_W;
   localparam int SW = sjc_pkg::SQ_W;
   localparam int TW = sjc_pkg::SQ_W + 1;

   sjc_pkg::side_type side_ff [N];
   logic [SW-1:0]     rem_ff  [N];
   logic [N-1:0]      root_ff [N];

   // One root bit per stage, most significant first.
   for (genvar s = 0; s < N; s++) begin : g_stage
      localparam int B = N - 1 - s;
      sjc_pkg::side_type side_p;
      logic [SW-1:0]     rem_p;
      logic [SW-1:0]     rem_in;
      logic [N-1:0]      root_p;
      logic [N-1:0]      root_in;
      logic [TW-1:0]     trial;

      if (s == 0) begin : g_first
         assign side_p = side_in;
         assign rem_p  = sq_in;
         assign root_p = '0;
      end else begin : g_next
         assign side_p = side_ff[s-1];
         assign rem_p  = rem_ff[s-1];
         assign root_p = root_ff[s-1];
      end

      always_comb begin
         trial = (TW'(root_p) << (B + 1)) | (TW'(1) << (2 * B));
         if (TW'(rem_p) >= trial) begin
            rem_in  = SW'(TW'(rem_p) - trial);
            root_in = root_p | (N'(1) << B);
         end else begin
            rem_in  = rem_p;
            root_in = root_p;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[s].valid <= 1'b0;
         end else if (adv) begin
            side_ff[s] <= side_p;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
         end
      end
   end

   assign side_out = side_ff[N-1];
   assign root_out = root_ff[N-1];

endmodule

// File: rtl/sjc_div_pipe.sv
module sjc_div_pipe (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               adv,
   input  sjc_pkg::side_type                                  side_in,
   input  logic [sjc_pkg::ROOT_W-1:0]                         divisor_in,
   input  logic [sjc_pkg::LANE_N-1:0][sjc_pkg::DIV_W-1:0]     dividend_in,
   output sjc_pkg::side_type                                  side_out,
   output logic [sjc_pkg::LANE_N-1:0][sjc_pkg::DIV_W-1:0]     quotient_out
);

   localparam int N  = sjc_pkg::DIV_W;
   localparam int L  = sjc_pkg::LANE_N;
   localparam int RW = sjc_pkg::ROOT_W;

   sjc_pkg::side_type            side_ff [N];
   logic [RW-1:0]                dvs_ff  [N];
   logic [L-1:0][N-1:0]          work_ff [N];
   logic [L-1:0][RW-1:0]         rem_ff  [N];

   // Restoring division, one quotient bit per stage for all lanes.
   for (genvar s = 0; s < N; s++) begin : g_stage
      sjc_pkg::side_type    side_p;
      logic [RW-1:0]        dvs_p;
      logic [L-1:0][N-1:0]  work_p;
      logic [L-1:0][N-1:0]  work_in;
      logic [L-1:0][RW-1:0] rem_p;
      logic [L-1:0][RW-1:0] rem_in;

      if (s == 0) begin : g_first
         assign side_p = side_in;
         assign dvs_p  = divisor_in;
         assign work_p = dividend_in;
         assign rem_p  = '0;
      end else begin : g_next
         assign side_p = side_ff[s-1];
         assign dvs_p  = dvs_ff[s-1];
         assign work_p = work_ff[s-1];
         assign rem_p  = rem_ff[s-1];
      end

      for (genvar l = 0; l < L; l++) begin : g_lane
         logic [RW:0] shifted;
         always_comb begin
            shifted = {rem_p[l], work_p[l][N-1]};
            if (shifted >= {1'b0, dvs_p}) begin
               rem_in[l]  = RW'(shifted - {1'b0, dvs_p});
               work_in[l] = {work_p[l][N-2:0], 1'b1};
            end else begin
               rem_in[l]  = shifted[RW-1:0];
               work_in[l] = {work_p[l][N-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[s].valid <= 1'b0;
         end else if (adv) begin
            side_ff[s] <= side_p;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dvs_ff[s]  <= dvs_p;
            work_ff[s] <= work_in;
            rem_ff[s]  <= rem_in;
         end
      end
   end

   assign side_out     = side_ff[N-1];
   assign quotient_out = work_ff[N-1];

endmodule

// File: rtl/sjc_stiff.sv
module sjc_stiff (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  sjc_pkg::side_type           side_in,
   input  logic [sjc_pkg::U_W-1:0]     um_x,
   input  logic [sjc_pkg::U_W-1:0]     um_y,
   input  logic [sjc_pkg::DIV_W-1:0]   q_in,
   output sjc_pkg::emit_type           item_out
);

   localparam int E   = sjc_pkg::ENT_N;
   localparam int UW  = sjc_pkg::U_W;
   localparam int KW  = sjc_pkg::KMAG_W;
   localparam int VW  = sjc_pkg::VAL_W;
   localparam int FW  = sjc_pkg::FRAC_W;

   sjc_pkg::side_type side_ff [6];

   logic [63:0]            pq_lo_ff;
   logic [47:0]            pq_hi_ff;
   logic [E-1:0][UW-1:0]   uu1_ff, uu2_ff;
   logic [E-1:0]           un1_ff, un2_ff, un3_ff, un4_ff;
   logic [KW-1:0]          beta_ff;
   logic signed [63:0]     alpha3_ff, alpha4_ff;
   logic [E-1:0][48:0]     tl_ff;
   logic [E-1:0][47:0]     th_ff;
   logic [E-1:0][KW-1:0]   tmag_ff;
   logic [E-1:0][KW-1:0]   kmag_ff;
   logic [E-1:0]           kneg5_ff, kneg6_ff;
   logic [1:0][E-1:0][63:0] vl_ff;
   logic [1:0][E-1:0][62:0] vh_ff;
   sjc_pkg::emit_type      out_ff;

   // Side information walks alongside the math.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 6; s++) side_ff[s].valid <= 1'b0;
      end else if (adv) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < 6; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   // Stage 1: k*q partial products, u_i*u_j.
   logic [1:0][UW-1:0] um;
   logic [1:0]         uneg;
   logic [63:0]        pq_lo_in;
   logic [47:0]        pq_hi_in;
   logic [E-1:0][UW-1:0] uu1_in;
   logic [E-1:0]       un1_in;

   always_comb begin
      um[0]   = um_x;
      um[1]   = um_y;
      uneg[0] = side_in.neg_x && (um_x != '0);
      uneg[1] = side_in.neg_y && (um_y != '0);
      pq_lo_in = 64'(side_in.stiff) * 64'(q_in[31:0]);
      pq_hi_in = 48'(side_in.stiff) * 48'(q_in[47:32]);
   end

   for (genvar n = 0; n < E; n++) begin : g_uu
      logic [2*UW-1:0] prod;
      always_comb begin
         prod       = (2*UW)'(um[n >> 1]) * (2*UW)'(um[n & 1]);
         uu1_in[n]  = prod[FW+UW-1:FW];
         un1_in[n]  = uneg[n >> 1] ^ uneg[n & 1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pq_lo_ff <= pq_lo_in;
         pq_hi_ff <= pq_hi_in;
         uu1_ff   <= uu1_in;
         un1_ff   <= un1_in;
      end
   end

   // Stage 2: beta = k*q >> 16, saturated.
   logic [79:0] pq_full;
   logic [63:0] beta_wide;
   logic [KW-1:0] beta_in;

   always_comb begin
      pq_full   = {pq_hi_ff, 32'h0} + 80'(pq_lo_ff);
      beta_wide = pq_full[79:FW];
      beta_in   = (beta_wide > 64'(sjc_pkg::SAT_LIM)) ? sjc_pkg::SAT_LIM : beta_wide[KW-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         beta_ff <= beta_in;
         uu2_ff  <= uu1_ff;
         un2_ff  <= un1_ff;
      end
   end

   // Stage 3: alpha = k - beta, beta*uu partial products.
   logic signed [63:0]  alpha3_in;
   logic [E-1:0][48:0]  tl_in;
   logic [E-1:0][47:0]  th_in;

   always_comb begin
      alpha3_in = $signed(64'(side_ff[1].stiff)) - $signed({1'b0, beta_ff});
      for (int n = 0; n < E; n++) begin
         tl_in[n] = 49'(beta_ff[31:0]) * 49'(uu2_ff[n]);
         th_in[n] = 48'(beta_ff[KW-1:32]) * 48'(uu2_ff[n]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         alpha3_ff <= alpha3_in;
         tl_ff     <= tl_in;
         th_ff     <= th_in;
         un3_ff    <= un2_ff;
      end
   end

   // Stage 4: |t| = beta*|uu| >> 16, saturated.
   logic [E-1:0][KW-1:0] tmag_in;

   for (genvar n = 0; n < E; n++) begin : g_tmag
      logic [79:0] tfull;
      logic [63:0] tw;
      always_comb begin
         tfull      = {th_ff[n], 32'h0} + 80'(tl_ff[n]);
         tw         = tfull[79:FW];
         tmag_in[n] = (tw > 64'(sjc_pkg::SAT_LIM)) ? sjc_pkg::SAT_LIM : tw[KW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tmag_ff   <= tmag_in;
         un4_ff    <= un3_ff;
         alpha4_ff <= alpha3_ff;
      end
   end

   // Stage 5: K = alpha*I + t, clamped.
   logic [E-1:0][KW-1:0] kmag_in;
   logic [E-1:0]         kneg_in;

   for (genvar n = 0; n < E; n++) begin : g_k
      logic signed [64:0] t_s;
      logic signed [64:0] sum_s;
      logic signed [64:0] lim_s;
      logic [64:0]        abs_v;
      always_comb begin
         lim_s = $signed({2'b00, sjc_pkg::SAT_LIM});
         t_s   = un4_ff[n] ? -$signed({2'b00, tmag_ff[n]}) : $signed({2'b00, tmag_ff[n]});
         if ((n == 0) || (n == E - 1)) begin
            sum_s = $signed({alpha4_ff[63], alpha4_ff}) + t_s;
         end else begin
            sum_s = t_s;
         end
         if (sum_s > lim_s) begin
            sum_s = lim_s;
         end else if (sum_s < -lim_s) begin
            sum_s = -lim_s;
         end
         kneg_in[n] = sum_s[64];
         abs_v      = sum_s[64] ? 65'(-sum_s) : 65'(sum_s);
         kmag_in[n] = abs_v[KW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kmag_ff  <= kmag_in;
         kneg5_ff <= kneg_in;
      end
   end

   // Stage 6: inverse mass times |K|, split in two halves.
   logic [1:0][E-1:0][63:0] vl_in;
   logic [1:0][E-1:0][62:0] vh_in;
   logic [1:0][31:0]        inv;

   always_comb begin
      inv[0] = side_ff[4].inv_a;
      inv[1] = side_ff[4].inv_b;
      for (int e = 0; e < 2; e++) begin
         for (int n = 0; n < E; n++) begin
            vl_in[e][n] = 64'(inv[e]) * 64'(kmag_ff[n][31:0]);
            vh_in[e][n] = 63'(inv[e]) * 63'(kmag_ff[n][KW-1:32]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vl_ff    <= vl_in;
         vh_ff    <= vh_in;
         kneg6_ff <= kneg5_ff;
      end
   end

   // Stage 7: >> 16 and cap the magnitude at the output range.
   logic [1:0][E-1:0][VW-1:0] vsat_in;

   for (genvar e = 0; e < 2; e++) begin : g_end
      for (genvar n = 0; n < E; n++) begin : g_ent
         logic [94:0] vfull;
         always_comb begin
            vfull = {vh_ff[e][n], 32'h0} + 95'(vl_ff[e][n]);
            vsat_in[e][n] = (vfull[94:63] != '0) ? sjc_pkg::OUT_MAG_MAX
                                                 : VW'(vfull[62:FW]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         out_ff.valid  <= side_ff[5].valid;
         out_ff.skip   <= side_ff[5].skip;
         out_ff.mass_a <= side_ff[5].mass_a;
         out_ff.mass_b <= side_ff[5].mass_b;
         out_ff.idx_a  <= side_ff[5].idx_a;
         out_ff.idx_b  <= side_ff[5].idx_b;
         out_ff.kneg   <= kneg6_ff;
         out_ff.vsat   <= vsat_in;
      end
   end

   assign item_out = out_ff;

endmodule

// File: rtl/sjc_emit.sv
module sjc_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  sjc_pkg::emit_type             item_in,
   output logic                          free,
   output logic                          rsp_strobe,
   output logic [sjc_pkg::ROW_W-1:0]     rsp_matrix_row,
   output logic [sjc_pkg::ROW_W-1:0]     rsp_matrix_col,
   output logic signed [sjc_pkg::VAL_W-1:0] rsp_delta_value,
   output logic                          rsp_last_of_spring
);

   localparam logic [3:0] STEP_FIRST_A = 4'd0;
   localparam logic [3:0] STEP_FIRST_B = 4'd8;
   localparam logic [3:0] STEP_LAST_2  = 4'd15;
   localparam logic [3:0] STEP_LAST_A  = 4'd6;
   localparam logic [3:0] STEP_LAST_B  = 4'd14;

   sjc_pkg::emit_type hold_ff;
   logic              active_ff;
   logic [3:0]        step_ff;

   logic       both, at_last, load;
   logic [3:0] last_step;

   always_comb begin
      both      = hold_ff.mass_a & hold_ff.mass_b;
      last_step = both ? STEP_LAST_2 : (hold_ff.mass_a ? STEP_LAST_A : STEP_LAST_B);
      at_last   = active_ff && (step_ff == last_step);
      free      = !active_ff || at_last;
      load      = item_in.valid && !item_in.skip && free;
   end

   // Step bits: end, row axis, column axis, own/other column.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (load) begin
         active_ff <= 1'b1;
         hold_ff   <= item_in;
         step_ff   <= item_in.mass_a ? STEP_FIRST_A : STEP_FIRST_B;
      end else if (at_last) begin
         active_ff <= 1'b0;
      end else if (active_ff) begin
         step_ff   <= step_ff + (both ? 4'd1 : 4'd2);
      end
   end

   logic [sjc_pkg::IDX_W-1:0] idx_e, idx_o;
   logic [1:0]                ent;
   logic                      neg;
   logic [sjc_pkg::VAL_W-1:0] vs;

   always_comb begin
      idx_e = step_ff[3] ? hold_ff.idx_b : hold_ff.idx_a;
      idx_o = step_ff[3] ? hold_ff.idx_a : hold_ff.idx_b;
      ent   = step_ff[2:1];
      vs    = hold_ff.vsat[step_ff[3]][ent];
      neg   = hold_ff.kneg[ent] ^ !step_ff[0];
      rsp_strobe         = active_ff;
      rsp_last_of_spring = at_last;
      rsp_matrix_row     = {idx_e, step_ff[2]};
      rsp_matrix_col     = step_ff[0] ? {idx_o, step_ff[1]} : {idx_e, step_ff[1]};
      if (neg) begin
         rsp_delta_value = $signed(-vs);
      end else if (vs[sjc_pkg::VAL_W-1]) begin
         rsp_delta_value = $signed(sjc_pkg::OUT_POS_MAX);
      end else begin
         rsp_delta_value = $signed(vs);
      end
   end

endmodule

// File: rtl/spring_jacobian_contribution_core.sv
// Stiffness Jacobian deltas of one 2D spring per item.
// Input: a spring item is taken at a rising edge with start high and busy low.
// Output: each delta (row, column, value, last flag) is shown for one cycle
// with rsp_strobe high; the consumer must take it then, it cannot push back.
// Config: csr_min_length is written whenever csr_valid is high (csr_ready is
// tied high); write it only while no spring is in flight.
// Pipeline: 4 front stages, 33 root stages, one length check, 48 divide
// stages and 7 stiffness stages lie between the accepting edge and the emitter.
// Throughput: the emitter sends one delta per cycle; a two-mass spring
// gives it 16 deltas, a one-mass spring 4; skipped springs give none.
// Items enter every cycle until a spring with deltas reaches the emitter
// while it is still sending; then the whole pipe holds and busy stays high.
// Reset: empties the pipe and the emitter, sets min_length to 1.
module spring_jacobian_contribution_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [sjc_pkg::POS_W-1:0]  req_end_a_x,
   input  logic signed [sjc_pkg::POS_W-1:0]  req_end_a_y,
   input  logic signed [sjc_pkg::POS_W-1:0]  req_end_b_x,
   input  logic signed [sjc_pkg::POS_W-1:0]  req_end_b_y,
   input  logic                              req_end_a_is_mass,
   input  logic                              req_end_b_is_mass,
   input  logic [sjc_pkg::IDX_W-1:0]         req_end_a_index,
   input  logic [sjc_pkg::IDX_W-1:0]         req_end_b_index,
   input  logic [sjc_pkg::Q_W-1:0]           req_spring_stiffness,
   input  logic [sjc_pkg::Q_W-1:0]           req_rest_length,
   input  logic [sjc_pkg::Q_W-1:0]           req_inv_mass_a,
   input  logic [sjc_pkg::Q_W-1:0]           req_inv_mass_b,
   output logic                              rsp_strobe,
   output logic [sjc_pkg::ROW_W-1:0]         rsp_matrix_row,
   output logic [sjc_pkg::ROW_W-1:0]         rsp_matrix_col,
   output logic signed [sjc_pkg::VAL_W-1:0]  rsp_delta_value,
   output logic                              rsp_last_of_spring,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sjc_pkg::LEN_W-1:0]         csr_min_length
);

   localparam int PW = sjc_pkg::POS_W;
   localparam int MW = sjc_pkg::MAG_W;
   localparam int RW = sjc_pkg::ROOT_W;
   localparam int FW = sjc_pkg::FRAC_W;
   localparam int UW = sjc_pkg::U_W;

   logic adv, stall, emit_free;

   // Degenerate-length threshold.
   logic [sjc_pkg::LEN_W-1:0] min_len_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= sjc_pkg::MIN_LEN_RST;
      end else if (csr_valid && csr_ready) begin
         min_len_ff <= csr_min_length;
      end
   end

   // Stage 0: capture the item; valid follows start since busy blocks adv.
   sjc_pkg::side_type s0_ff, s0_in;
   logic signed [PW-1:0] ax_ff, ay_ff, bx_ff, by_ff;

   always_comb begin
      s0_in        = '0;
      s0_in.valid  = start;
      s0_in.mass_a = req_end_a_is_mass;
      s0_in.mass_b = req_end_b_is_mass;
      s0_in.idx_a  = req_end_a_index;
      s0_in.idx_b  = req_end_b_index;
      s0_in.stiff  = req_spring_stiffness;
      s0_in.rest   = req_rest_length;
      s0_in.inv_a  = req_inv_mass_a;
      s0_in.inv_b  = req_inv_mass_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
      end else if (adv) begin
         s0_ff <= s0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff <= req_end_a_x;
         ay_ff <= req_end_a_y;
         bx_ff <= req_end_b_x;
         by_ff <= req_end_b_y;
      end
   end

   // Stage 1: difference vector as sign and magnitude; early skip checks.
   sjc_pkg::side_type f1_ff, f1_in;
   logic signed [PW:0] dx, dy;
   logic [PW:0]        ndx, ndy;

   always_comb begin
      dx    = (PW+1)'(bx_ff) - (PW+1)'(ax_ff);
      dy    = (PW+1)'(by_ff) - (PW+1)'(ay_ff);
      ndx   = -dx;
      ndy   = -dy;
      f1_in = s0_ff;
      f1_in.neg_x = dx[PW];
      f1_in.neg_y = dy[PW];
      f1_in.mag_x = dx[PW] ? ndx[MW-1:0] : dx[MW-1:0];
      f1_in.mag_y = dy[PW] ? ndy[MW-1:0] : dy[MW-1:0];
      // Both ends fixed, or a mass index past the end of the mass table.
      f1_in.skip  = !(s0_ff.mass_a || s0_ff.mass_b)
                 || (s0_ff.mass_a && (32'(s0_ff.idx_a) >= sjc_pkg::MAX_MASSES))
                 || (s0_ff.mass_b && (32'(s0_ff.idx_b) >= sjc_pkg::MAX_MASSES));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_ff.valid <= 1'b0;
      end else if (adv) begin
         f1_ff <= f1_in;
      end
   end

   // Stage 2: squares.
   sjc_pkg::side_type f2_ff;
   logic [2*MW-1:0]   sqx_ff, sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_ff.valid <= 1'b0;
      end else if (adv) begin
         f2_ff <= f1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff <= (2*MW)'(f1_ff.mag_x) * (2*MW)'(f1_ff.mag_x);
         sqy_ff <= (2*MW)'(f1_ff.mag_y) * (2*MW)'(f1_ff.mag_y);
      end
   end

   // Stage 3: squared length.
   sjc_pkg::side_type          f3_ff;
   logic [sjc_pkg::SQ_W-1:0]   sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f3_ff.valid <= 1'b0;
      end else if (adv) begin
         f3_ff <= f2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= sjc_pkg::SQ_W'(sqx_ff) + sjc_pkg::SQ_W'(sqy_ff);
      end
   end

   // Integer square root, one bit per stage.
   sjc_pkg::side_type side_sq;
   logic [RW-1:0]     root;

   sjc_sqrt_pipe u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .side_in  (f3_ff),
      .sq_in    (sum_ff),
      .side_out (side_sq),
      .root_out (root)
   );

   // Length check: drop zero-length and too-short springs.
   sjc_pkg::side_type chk_ff, chk_in;
   logic [RW-1:0]     root_ff;

   always_comb begin
      chk_in      = side_sq;
      chk_in.skip = side_sq.skip || (root == '0) || (root < RW'(min_len_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_ff.valid <= 1'b0;
      end else if (adv) begin
         chk_ff <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         root_ff <= root;
      end
   end

   // Unit direction and l0/r in one three-lane divider.
   logic [sjc_pkg::LANE_N-1:0][sjc_pkg::DIV_W-1:0] dividend, quotient;
   sjc_pkg::side_type side_dv;

   always_comb begin
      dividend[sjc_pkg::LANE_UX] = {chk_ff.mag_x, FW'(0)};
      dividend[sjc_pkg::LANE_UY] = {chk_ff.mag_y, FW'(0)};
      dividend[sjc_pkg::LANE_Q]  = {chk_ff.rest, FW'(0)};
   end

   sjc_div_pipe u_div (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .side_in      (chk_ff),
      .divisor_in   (root_ff),
      .dividend_in  (dividend),
      .side_out     (side_dv),
      .quotient_out (quotient)
   );

   // Local stiffness block and mass-scaled values.
   sjc_pkg::emit_type item;

   sjc_stiff u_stiff (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .side_in  (side_dv),
      .um_x     (quotient[sjc_pkg::LANE_UX][UW-1:0]),
      .um_y     (quotient[sjc_pkg::LANE_UY][UW-1:0]),
      .q_in     (quotient[sjc_pkg::LANE_Q]),
      .item_out (item)
   );

   // Hold the whole pipe while a spring with deltas waits for the emitter.
   always_comb begin
      stall = item.valid && !item.skip && !emit_free;
      adv   = !stall;
      busy  = stall;
   end

   sjc_emit u_emit (
      .clock              (clock),
      .reset              (reset),
      .item_in            (item),
      .free               (emit_free),
      .rsp_strobe         (rsp_strobe),
      .rsp_matrix_row     (rsp_matrix_row),
      .rsp_matrix_col     (rsp_matrix_col),
      .rsp_delta_value    (rsp_delta_value),
      .rsp_last_of_spring (rsp_last_of_spring)
   );

endmodule

// File: rtl/sjc_checker.sv
`include "spring_jacobian_contribution_core_macros.svh"

module sjc_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic csr_valid,
   input logic csr_ready,
   input logic rsp_strobe,
   input logic rsp_last_of_spring
);

   // Deltas of one spring come out back to back.
   `SJC_ASSERT_NEXT(a_spring_contiguous, rsp_strobe && !rsp_last_of_spring, rsp_strobe)

   // The last flag only rides on a strobed delta.
   `SJC_ASSERT_NOW(a_last_has_strobe, rsp_last_of_spring, rsp_strobe)

   // The register write is never refused.
   `SJC_ASSERT_NOW(a_csr_taken, csr_valid, csr_ready)

   // Leaving reset the pipe is empty, so nothing holds the input off.
   `SJC_ASSERT_NOW(a_idle_after_reset, $fell(reset), !busy)

endmodule

bind spring_jacobian_contribution_core sjc_checker u_sjc_checker (.*);

// File: tb/tb_top.sv
module tb_top;

   localparam int SETTLE_CYCLES = 130;     // pipe depth is 93, keep margin
   localparam int CYCLE_LIMIT   = 400000;
   localparam longint LIM62     = 64'sh4000_0000_0000_0000;
   localparam longint OUT_HI    = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint OUT_LO    = -64'sh0000_8000_0000_0000;

   typedef struct {
      logic signed [31:0] ax, ay, bx, by;
      logic               ma, mb;
      logic [5:0]         ia, ib;
      logic [31:0]        k, l0, inva, invb;
      int                 want_n;   // -1: leave it to the predictor
   } spring_type;

   typedef struct {
      logic [6:0]  row, col;
      logic [47:0] val;
      logic        last;
   } delta_type;

   logic clock, reset, start, busy;
   logic signed [31:0] req_end_a_x, req_end_a_y, req_end_b_x, req_end_b_y;
   logic req_end_a_is_mass, req_end_b_is_mass;
   logic [5:0] req_end_a_index, req_end_b_index;
   logic [31:0] req_spring_stiffness, req_rest_length, req_inv_mass_a, req_inv_mass_b;
   logic rsp_strobe, rsp_last_of_spring;
   logic [6:0] rsp_matrix_row, rsp_matrix_col;
   logic signed [47:0] rsp_delta_value;
   logic csr_valid, csr_ready;
   logic [15:0] csr_min_length;

   delta_type   delta_q[$];   // deltas still owed by the block
   logic [15:0] min_len_mirror;
   int          errors;
   int          cycles;

   spring_jacobian_contribution_core i_dut (
      .clock, .reset, .start, .busy,
      .req_end_a_x, .req_end_a_y, .req_end_b_x, .req_end_b_y,
      .req_end_a_is_mass, .req_end_b_is_mass, .req_end_a_index, .req_end_b_index,
      .req_spring_stiffness, .req_rest_length, .req_inv_mass_a, .req_inv_mass_b,
      .rsp_strobe, .rsp_matrix_row, .rsp_matrix_col, .rsp_delta_value,
      .rsp_last_of_spring, .csr_valid, .csr_ready, .csr_min_length
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   task automatic report(input string what);
      errors++;
      $display("mismatch @%0d: %s", cycles, what);
   endtask

   // Floor square root of a 66-bit sum of squares, bit by bit.
   function automatic logic [33:0] root66(input logic [65:0] s);
      logic [33:0] res;
      logic [33:0] c;
      logic [67:0] sq;
      res = '0;
      for (int b = 33; b >= 0; b--) begin
         c  = res | (34'd1 << b);
         sq = 68'(c) * 68'(c);
         if (sq <= 68'(s)) res = c;
      end
      return res;
   endfunction

   function automatic logic [63:0] magof(input longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   // Q16.16 multiply of magnitudes, truncated, saturated to 2^62.
   function automatic longint fxmul(input longint a, input longint b);
      logic [127:0] p;
      logic [127:0] m;
      longint       r;
      p = 128'(magof(a)) * 128'(magof(b));
      m = p >> 16;
      if (m > 128'(LIM62)) m = 128'(LIM62);
      r = longint'(m[63:0]);
      return ((a < 0) != (b < 0)) ? -r : r;
   endfunction

   function automatic longint clamp62(input longint v);
      if (v > LIM62) return LIM62;
      if (v < -LIM62) return -LIM62;
      return v;
   endfunction

   // Queue the deltas one spring should yield; return how many.
   function automatic int predict_deltas(input spring_type s);
      longint      d[2], u[2], kk[2][2], beta, alpha, pm, uu, t, v, invm[2];
      logic [63:0] ud[2];
      logic [65:0] sum;
      logic [33:0] r;
      logic [63:0] q, m;
      logic        mass[2];
      logic [5:0]  idx[2];
      int          n;
      delta_type   dl;
      n = 0;
      mass[0] = s.ma; mass[1] = s.mb;
      idx[0] = s.ia;  idx[1] = s.ib;
      if (!mass[0] && !mass[1]) return 0;
      d[0] = longint'(s.bx) - longint'(s.ax);
      d[1] = longint'(s.by) - longint'(s.ay);
      ud[0] = magof(d[0]);
      ud[1] = magof(d[1]);
      sum = 66'(ud[0]) * 66'(ud[0]) + 66'(ud[1]) * 66'(ud[1]);
      r = root66(sum);
      if (r == 0 || r < 34'(min_len_mirror)) return 0;
      for (int i = 0; i < 2; i++) begin
         m = (ud[i] << 16) / 64'(r);
         u[i] = d[i] < 0 ? -longint'(m) : longint'(m);
      end
      q = (64'(s.l0) << 16) / 64'(r);
      beta  = fxmul(longint'(s.k), longint'(q));
      alpha = clamp62(longint'(s.k) - beta);
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++) begin
            pm = longint'((magof(u[i]) * magof(u[j])) >> 16);
            uu = ((u[i] < 0) != (u[j] < 0)) ? -pm : pm;
            t  = fxmul(beta, uu);
            kk[i][j] = clamp62(i == j ? alpha + t : t);
         end
      invm[0] = longint'(s.inva);
      invm[1] = longint'(s.invb);
      for (int e = 0; e < 2; e++) begin
         if (!mass[e]) continue;
         for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++) begin
               v = fxmul(invm[e], kk[i][j]);
               for (int side = 0; side < 2; side++) begin
                  longint w;
                  if (side == 1 && !mass[1-e]) continue;
                  w = side == 0 ? -v : v;
                  if (w > OUT_HI) w = OUT_HI;
                  if (w < OUT_LO) w = OUT_LO;
                  dl.row  = {idx[e], 1'(i)};
                  dl.col  = {side == 0 ? idx[e] : idx[1-e], 1'(j)};
                  dl.val  = w[47:0];
                  dl.last = 1'b0;
                  delta_q.insert(delta_q.size(), dl);
                  n++;
               end
            end
      end
      if (n > 0) delta_q[delta_q.size()-1].last = 1'b1;
      return n;
   endfunction

   // Check each delta as it leaves; the block cannot be held off.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (delta_q.size() == 0) begin
            report($sformatf("unexpected delta row %0d col %0d", rsp_matrix_row,
                             rsp_matrix_col));
         end else begin
            delta_type e;
            e = delta_q.pop_front();
            if (rsp_matrix_row !== e.row)
               report($sformatf("row %0d, want %0d", rsp_matrix_row, e.row));
            if (rsp_matrix_col !== e.col)
               report($sformatf("col %0d, want %0d", rsp_matrix_col, e.col));
            if (rsp_delta_value !== e.val)
               report($sformatf("value %h, want %h", rsp_delta_value, e.val));
            if (rsp_last_of_spring !== e.last)
               report($sformatf("last %b, want %b", rsp_last_of_spring, e.last));
         end
      end
   end

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Present one spring, hold it until taken, then idle a random while.
   task automatic send_spring(input spring_type s);
      int got, gap;
      req_end_a_x <= s.ax;  req_end_a_y <= s.ay;
      req_end_b_x <= s.bx;  req_end_b_y <= s.by;
      req_end_a_is_mass <= s.ma;  req_end_b_is_mass <= s.mb;
      req_end_a_index <= s.ia;    req_end_b_index <= s.ib;
      req_spring_stiffness <= s.k;  req_rest_length <= s.l0;
      req_inv_mass_a <= s.inva;     req_inv_mass_b <= s.invb;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      got = predict_deltas(s);
      if (s.want_n >= 0 && got != s.want_n)
         report($sformatf("spring gives %0d deltas, want %0d", got, s.want_n));
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drain every owed delta, then let skipped springs clear the pipe.
   task automatic drain_pipe();
      start <= 1'b0;
      while (delta_q.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_length(input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_min_length <= v;
      do @(posedge clock); while (!csr_ready);
      min_len_mirror = v;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 32'h0004_0000);
         default: return $urandom;
      endcase
   endfunction

   // Random spring: mostly masses with moderate geometry, some wide noise.
   function automatic spring_type random_spring();
      spring_type s;
      logic signed [31:0] base_x, base_y;
      base_x = $urandom;
      base_y = $urandom;
      s.ax = base_x;  s.ay = base_y;
      if ($urandom_range(0, 3) == 0) begin
         s.bx = $urandom;
         s.by = $urandom;
      end else begin
         s.bx = base_x + 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
         s.by = base_y + 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
      end
      if ($urandom_range(0, 9) == 0) begin
         s.bx = s.ax;  s.by = s.ay;
      end
      case ($urandom_range(0, 7))
         0: begin s.ma = 1'b1; s.mb = 1'b0; end
         1: begin s.ma = 1'b0; s.mb = 1'b1; end
         2: begin s.ma = 1'b0; s.mb = 1'b0; end
         default: begin s.ma = 1'b1; s.mb = 1'b1; end
      endcase
      s.ia = 6'($urandom);
      s.ib = ($urandom_range(0, 9) == 0) ? s.ia : 6'($urandom);
      s.k    = pick32();
      s.l0   = pick32();
      s.inva = pick32();
      s.invb = pick32();
      s.want_n = -1;
      return s;
   endfunction

   spring_type directed_tbl[11] = '{
      // both ends fixed
      '{32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0, 1'b0, 1'b0, 6'd1, 6'd2,
        32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0001_0000, 0},
      // coincident ends
      '{32'sh0003_0000, 32'sh0003_0000, 32'sh0003_0000, 32'sh0003_0000, 1'b1, 1'b1,
        6'd4, 6'd5, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0},
      // only end a moves
      '{32'sh0, 32'sh0, 32'sh0003_0000, 32'sh0004_0000, 1'b1, 1'b0, 6'd0, 6'd63,
        32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0, 4},
      // only end b moves
      '{32'sh0, 32'sh0, -32'sh0003_0000, 32'sh0004_0000, 1'b0, 1'b1, 6'd63, 6'd0,
        32'h0002_0000, 32'h0008_0000, 32'h0, 32'h0000_8000, 4},
      // two masses, top indexes
      '{32'sh0001_0000, -32'sh0002_0000, 32'sh0005_0000, 32'sh0001_0000, 1'b1, 1'b1,
        6'd62, 6'd63, 32'h0010_0000, 32'h0002_0000, 32'h0001_0000, 32'h0000_4000, 16},
      // same mass at both ends
      '{32'sh0, 32'sh0, 32'sh0, 32'sh0002_0000, 1'b1, 1'b1, 6'd7, 6'd7,
        32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16},
      // widest span, all scalars at max: saturation throughout
      '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 1'b1,
        6'd63, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16},
      // tiny length with huge rest length
      '{32'sh0, 32'sh0, 32'sh0000_0001, 32'sh0, 1'b1, 1'b1, 6'd10, 6'd11,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 16},
      // zero stiffness
      '{32'sh0, 32'sh0, 32'sh0002_0000, -32'sh0002_0000, 1'b1, 1'b1, 6'd20, 6'd21,
        32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, -1},
      // zero rest length, pure diagonal axis
      '{-32'sh0004_0000, 32'sh0, 32'sh0004_0000, 32'sh0, 1'b1, 1'b1, 6'd30, 6'd31,
        32'h0003_0000, 32'h0, 32'hFFFF_FFFF, 32'h0, -1},
      // negative diagonal
      '{32'sh7FFF_FFFF, 32'sh0, 32'sh8000_0000, 32'sh0000_0001, 1'b0, 1'b1, 6'd0,
        6'd33, 32'h8000_0000, 32'h0000_0001, 32'h0, 32'h8000_0000, 4}
   };

   initial begin
      errors = 0;
      cycles = 0;
      min_len_mirror = sjc_pkg::MIN_LEN_RST;
      reset = 1'b1;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_min_length = '0;
      {req_end_a_x, req_end_a_y, req_end_b_x, req_end_b_y} = '0;
      {req_end_a_is_mass, req_end_b_is_mass, req_end_a_index, req_end_b_index} = '0;
      {req_spring_stiffness, req_rest_length, req_inv_mass_a, req_inv_mass_b} = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows at reset min_length, then again with the check off.
      foreach (directed_tbl[i]) send_spring(directed_tbl[i]);
      drain_pipe();
      write_min_length(16'h0000);
      foreach (directed_tbl[i]) send_spring(directed_tbl[i]);

      // Random phases across min_length settings; each change waits for idle.
      for (int ph = 0; ph < 4; ph++) begin
         drain_pipe();
         case (ph)
            0: write_min_length(16'hFFFF);
            1: write_min_length(16'h0001);
            2: write_min_length(16'h0000);
            default: write_min_length(16'($urandom));
         endcase
         for (int n = 0; n < 110; n++) send_spring(random_spring());
      end

      drain_pipe();
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
